### design/rtfd_pkg.sv
`default_nettype none

package rtfd_pkg;

    // Frame geometry
    localparam int NUM_TARGETS   = 3;
    localparam int RECORD_BYTES  = 8;
    localparam int HEADER_LEN    = 4;
    localparam int PAYLOAD_LEN   = NUM_TARGETS * RECORD_BYTES;
    localparam int MIN_FRAME_LEN = HEADER_LEN + PAYLOAD_LEN + 1;
    localparam int COUNT_SAT     = (MIN_FRAME_LEN > 31) ? MIN_FRAME_LEN : 31;
    localparam int CNT_W         = $clog2(COUNT_SAT + 1);

    // Payload memory: 16-bit words, two banks of one frame each
    localparam int PAYLOAD_WORDS = PAYLOAD_LEN / 2;
    localparam int WORDS_PER_REC = RECORD_BYTES / 2;
    localparam int WIDX_W        = $clog2(PAYLOAD_WORDS);
    localparam int ADDR_W        = WIDX_W + 1;
    localparam int RAM_DEPTH     = 2 ** ADDR_W;
    localparam int TGT_W         = (NUM_TARGETS > 1) ? $clog2(NUM_TARGETS) : 1;

    // Input item kinds
    localparam logic [1:0] MODE_BYTE = 2'd0;
    localparam logic [1:0] MODE_END  = 2'd1;
    localparam logic [1:0] MODE_TICK = 2'd2;

    // Word order inside a target record
    localparam logic [1:0] WORD_X     = 2'd0;
    localparam logic [1:0] WORD_Y     = 2'd1;
    localparam logic [1:0] WORD_SPEED = 2'd2;
    localparam logic [1:0] WORD_RES   = 2'd3;

    // Frame markers and limits
    localparam logic [15:0] TAIL_WORD        = 16'h55CC;
    localparam logic [15:0] INTERVAL_DEFAULT = 16'd1000;
    localparam logic [15:0] MS_MAX           = 16'hFFFF;
    // ceil(2^19 / 10): exact quotient by 10 for every 15-bit magnitude
    localparam logic [15:0] DIV10_MUL        = 16'd52429;

    // Result tdata layout
    localparam int POS_W      = 13;
    localparam int Y_LSB      = 13;
    localparam int SPEED_LSB  = 26;
    localparam int RES_LSB    = 42;
    localparam int CNT_LSB    = 58;
    localparam int OUT_DATA_W = 64;

    // Start request from the frame checker to the record decoder
    typedef struct packed {
        logic start;
        logic bank;
    } dec_start_t;

    // Expected header byte at a given position
    function automatic logic [7:0] header_byte(input logic [1:0] pos);
        logic [7:0] val;
        case (pos)
            2'd0:    val = 8'hAA;
            2'd1:    val = 8'hFF;
            2'd2:    val = 8'h03;
            default: val = 8'h00;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

### design/rtfd_ram.sv
`default_nettype none

module rtfd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port; read data holds without a read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### design/rtfd_frontend.sv
`default_nettype none

module rtfd_frontend (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      xfer,
    input  wire logic [1:0]                mode,
    input  wire logic [7:0]                data_byte,
    input  wire logic                      cfg_wr_en,
    input  wire logic [15:0]               cfg_wr_data,
    output rtfd_pkg::dec_start_t           dec_start,
    output logic                           ram_we,
    output logic [rtfd_pkg::ADDR_W-1:0]    ram_waddr,
    output logic [15:0]                    ram_wdata
);

    import rtfd_pkg::*;

    logic [CNT_W-1:0] count_reg, count_next;
    logic             header_ok_reg, header_ok_next;
    logic [15:0]      tail_reg, tail_next;
    logic [15:0]      ms_reg, ms_next;
    logic [15:0]      interval_reg, interval_next;
    logic             bank_reg, bank_next;
    logic [7:0]       low_hold_reg, low_hold_next;
    logic [CNT_W-1:0] pidx;
    logic             in_payload;
    logic             frame_ok;

    // Position of the current byte inside the payload.
    assign pidx       = count_reg - CNT_W'(HEADER_LEN);
    assign in_payload = (count_reg >= CNT_W'(HEADER_LEN)) &&
                        (count_reg < CNT_W'(HEADER_LEN + PAYLOAD_LEN));

    // A frame passes on length, header, tail and the rate limit.
    assign frame_ok = (count_reg >= CNT_W'(MIN_FRAME_LEN)) && header_ok_reg &&
                      (tail_reg == TAIL_WORD) && (ms_reg >= interval_reg);

    // Byte collection, frame check and tick counting.
    always_comb
    begin
        count_next     = count_reg;
        header_ok_next = header_ok_reg;
        tail_next      = tail_reg;
        ms_next        = ms_reg;
        bank_next      = bank_reg;
        low_hold_next  = low_hold_reg;
        interval_next  = cfg_wr_en ? cfg_wr_data : interval_reg;
        ram_we         = 1'b0;
        ram_waddr      = {bank_reg, pidx[WIDX_W:1]};
        ram_wdata      = {data_byte, low_hold_reg};
        dec_start      = '{start: 1'b0, bank: bank_reg};
        if (xfer)
        begin
            case (mode)
                MODE_BYTE:
                begin
                    if (count_reg < CNT_W'(HEADER_LEN))
                    begin
                        if (data_byte != header_byte(count_reg[1:0]))
                        begin
                            header_ok_next = 1'b0;
                        end
                    end
                    // Even payload bytes wait for their high byte, then the word is written.
                    if (in_payload)
                    begin
                        if (pidx[0] == 1'b0)
                        begin
                            low_hold_next = data_byte;
                        end
                        else
                        begin
                            ram_we = 1'b1;
                        end
                    end
                    tail_next = {tail_reg[7:0], data_byte};
                    if (count_reg < CNT_W'(COUNT_SAT))
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                MODE_END:
                begin
                    count_next     = '0;
                    header_ok_next = 1'b1;
                    tail_next      = '0;
                    if (frame_ok)
                    begin
                        ms_next         = '0;
                        bank_next       = ~bank_reg;
                        dec_start.start = 1'b1;
                    end
                end
                MODE_TICK:
                begin
                    if (ms_reg != MS_MAX)
                    begin
                        ms_next = ms_reg + 16'd1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            header_ok_reg <= 1'b1;
            tail_reg      <= '0;
            ms_reg        <= '0;
            interval_reg  <= INTERVAL_DEFAULT;
            bank_reg      <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            header_ok_reg <= header_ok_next;
            tail_reg      <= tail_next;
            ms_reg        <= ms_next;
            interval_reg  <= interval_next;
            bank_reg      <= bank_next;
        end
    end

    // Low byte holding register.
    always_ff @(posedge clk)
    begin
        low_hold_reg <= low_hold_next;
    end

endmodule

`default_nettype wire

### design/rtfd_decoder.sv
`default_nettype none

module rtfd_decoder (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire rtfd_pkg::dec_start_t             dec_start,
    input  wire logic [15:0]                      ram_rdata,
    input  wire logic                             out_ready,
    output logic                                  busy,
    output logic                                  ram_re,
    output logic [rtfd_pkg::ADDR_W-1:0]           ram_raddr,
    output logic                                  out_valid,
    output logic [rtfd_pkg::OUT_DATA_W-1:0]       out_data,
    output logic [1:0]                            out_index,
    output logic                                  out_last
);

    import rtfd_pkg::*;

    logic                   active_reg, active_next;
    logic                   pend_reg, pend_next;
    logic [TGT_W-1:0]       target_reg, target_next;
    logic [1:0]             word_reg, word_next;
    logic                   bank_reg, bank_next;
    logic [NUM_TARGETS-1:0] nz_reg, nz_next;
    logic [POS_W-1:0]       x_reg, y_reg;
    logic [15:0]            speed_reg;
    logic                   ovalid_reg, ovalid_next;
    logic [OUT_DATA_W-1:0]  odata_reg;
    logic [1:0]             oindex_reg;
    logic                   olast_reg;

    logic                   slot_free;
    logic                   emit;
    logic                   last_tgt;
    logic [TGT_W-1:0]       issue_target;
    logic [1:0]             issue_word;
    logic [30:0]            prod;
    logic [11:0]            mag10;
    logic [POS_W-1:0]       pos_val;
    logic [15:0]            speed_val;
    logic [3:0]             nz_count;

    // Divide the 15-bit magnitude by 10 for the positions (not the speed) and apply the inverted sign bit.
    assign prod      = 31'(ram_rdata[14:0]) * 31'(DIV10_MUL);
    assign mag10     = prod[30:19];
    assign pos_val   = ram_rdata[15] ? {1'b0, mag10} : (POS_W'(0) - {1'b0, mag10});
    assign speed_val = ram_rdata[15] ? {1'b0, ram_rdata[14:0]}
                                     : (16'd0 - {1'b0, ram_rdata[14:0]});

    // Sequencer: four word reads per target, the result leaves with the last one.
    assign slot_free = !ovalid_reg || out_ready;
    assign last_tgt  = (target_reg == TGT_W'(NUM_TARGETS - 1));
    assign emit      = pend_reg && (word_reg == WORD_RES) && slot_free;

    always_comb
    begin
        issue_target = target_reg;
        issue_word   = WORD_X;
        ram_re       = 1'b0;
        if (active_reg)
        begin
            if (!pend_reg)
            begin
                ram_re = 1'b1;
            end
            else if (word_reg != WORD_RES)
            begin
                ram_re     = 1'b1;
                issue_word = word_reg + 2'd1;
            end
            else if (emit && !last_tgt)
            begin
                ram_re       = 1'b1;
                issue_target = target_reg + TGT_W'(1);
            end
        end
        ram_raddr = {bank_reg, WIDX_W'({issue_target, issue_word})};
    end

    // Stored resolutions that are nonzero, including the one just read.
    always_comb
    begin
        nz_next = nz_reg;
        if (emit)
        begin
            nz_next[target_reg] = (ram_rdata != 16'd0);
        end
        nz_count = '0;
        for (int i = 0; i < NUM_TARGETS; i++)
        begin
            nz_count = nz_count + 4'(nz_next[i]);
        end
    end

    // Next control state.
    always_comb
    begin
        active_next = active_reg;
        pend_next   = pend_reg;
        target_next = target_reg;
        word_next   = word_reg;
        bank_next   = bank_reg;
        ovalid_next = ovalid_reg;
        if (dec_start.start)
        begin
            active_next = 1'b1;
            pend_next   = 1'b0;
            target_next = '0;
            bank_next   = dec_start.bank;
        end
        else if (ram_re)
        begin
            pend_next   = 1'b1;
            word_next   = issue_word;
            target_next = issue_target;
        end
        else if (emit)
        begin
            active_next = 1'b0;
            pend_next   = 1'b0;
        end
        if (emit)
        begin
            ovalid_next = 1'b1;
        end
        else if (out_ready)
        begin
            ovalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            pend_reg   <= 1'b0;
            target_reg <= '0;
            word_reg   <= WORD_X;
            bank_reg   <= 1'b0;
            nz_reg     <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            pend_reg   <= pend_next;
            target_reg <= target_next;
            word_reg   <= word_next;
            bank_reg   <= bank_next;
            nz_reg     <= nz_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // Field capture and the output register.
    always_ff @(posedge clk)
    begin
        if (pend_reg && (word_reg == WORD_X))
        begin
            x_reg <= pos_val;
        end
        if (pend_reg && (word_reg == WORD_Y))
        begin
            y_reg <= pos_val;
        end
        if (pend_reg && (word_reg == WORD_SPEED))
        begin
            speed_reg <= speed_val;
        end
        if (emit)
        begin
            odata_reg  <= {(OUT_DATA_W - CNT_LSB - 2)'(0), nz_count[1:0], ram_rdata,
                           speed_reg, y_reg, x_reg};
            oindex_reg <= 2'(target_reg);
            olast_reg  <= last_tgt;
        end
    end

    assign busy      = active_reg;
    assign out_valid = ovalid_reg;
    assign out_data  = odata_reg;
    assign out_index = oindex_reg;
    assign out_last  = olast_reg;

endmodule

`default_nettype wire

### design/radar_target_frame_decoder.sv
// Radar target report frame decoder.
//
// Input stream (s_axis): one transaction per item. tuser carries the kind
// (0 received byte, 1 end of frame, 2 one-millisecond tick, 3 ignored) and
// tdata carries the received byte. Bytes and ticks are taken every cycle.
// An end-of-frame transaction is held off (tready low) while the previous
// accepted frame is still being decoded, which output stalls prolong.
// Output stream (m_axis): three results per accepted frame, tuser is the
// target index and tlast marks the third. Decoding starts on the
// end-of-frame transaction, and each result is built from the four 16-bit
// reads of its target, made in turn through the single payload memory port.
// A stalled receiver holds the output register and pauses the reads.
// Configuration: cfg_wr_en writes cfg_wr_data into the rate limit (ms).
// Reset clears the counters, loads a rate limit of 1000 and clears the
// stored resolutions; the payload memory is not cleared and needs no pass.
// Payload bytes land in a two-bank memory so a new frame can stream in
// while the previous one is decoded.
`default_nettype none

module radar_target_frame_decoder (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic [1:0]  s_axis_tuser,   // [1:0] mode
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [12:0] x_pos, [25:13] y_pos, [41:26] speed, [57:42] resolution,
    // [59:58] target_count, [63:60] zero
    output logic [63:0]      m_axis_tdata,
    output logic [1:0]       m_axis_tuser,   // [1:0] target_index
    output logic             m_axis_tlast,   // last_of_frame
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data
);

    import rtfd_pkg::*;

    dec_start_t        dec_start;
    logic              dec_busy;
    logic              xfer;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [15:0]       ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [15:0]       ram_rdata;

    // Only an end mark waits for the decoder to finish the previous frame.
    assign s_axis_tready = !(dec_busy && (s_axis_tuser == MODE_END));
    assign xfer          = s_axis_tvalid && s_axis_tready;

    rtfd_frontend u_frontend (
        .clk        (clk),
        .rst_n      (rst_n),
        .xfer       (xfer),
        .mode       (s_axis_tuser),
        .data_byte  (s_axis_tdata),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .dec_start  (dec_start),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata)
    );

    rtfd_ram #(
        .WIDTH(16),
        .DEPTH(RAM_DEPTH)
    ) u_payload_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    rtfd_decoder u_decoder (
        .clk      (clk),
        .rst_n    (rst_n),
        .dec_start(dec_start),
        .ram_rdata(ram_rdata),
        .out_ready(m_axis_tready),
        .busy     (dec_busy),
        .ram_re   (ram_re),
        .ram_raddr(ram_raddr),
        .out_valid(m_axis_tvalid),
        .out_data (m_axis_tdata),
        .out_index(m_axis_tuser),
        .out_last (m_axis_tlast)
    );

endmodule

`default_nettype wire

### design/rtfd_checker.sv
`default_nettype none

module rtfd_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic [1:0]  s_axis_tuser,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [63:0] m_axis_tdata,
    input wire logic [1:0]  m_axis_tuser,
    input wire logic        m_axis_tlast
);

    import rtfd_pkg::*;

    // A stalled result transaction keeps its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
            $stable(m_axis_tlast))
        else $error("result transaction changed while stalled");

    // The frame's final result belongs to the last target.
    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == 2'(NUM_TARGETS - 1))
        else $error("last result carries the wrong target index");

    // A nonzero resolution is always counted.
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        (NUM_TARGETS < 4) && m_axis_tvalid && (m_axis_tdata[RES_LSB +: 16] != 16'd0) |->
            m_axis_tdata[CNT_LSB +: 2] != 2'd0)
        else $error("target count misses a nonzero resolution");

    // Bytes and ticks are never held off.
    a_no_byte_stall: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && (s_axis_tuser != MODE_END) |-> s_axis_tready)
        else $error("byte or tick transaction was stalled");

endmodule

bind radar_target_frame_decoder rtfd_checker u_rtfd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
);

`default_nettype wire
